>>> hw/rtl/hua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP User-Agent extract package
// Shared types, character constants and match tables.
// ----------------------------------------------------------------------------
package hua_pkg;

   localparam int CNT_W      = 6;
   localparam int KEY_LEN    = 11;
   localparam int PREFIX_LEN = 3;

   localparam logic [7:0] BYTE_CR    = 8'd13;
   localparam logic [7:0] BYTE_COMMA = 8'd44;
   localparam logic [7:0] BYTE_SEMI  = 8'd59;
   localparam logic [7:0] BYTE_NUL   = 8'd0;

   // buffer write from the line parser
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [CNT_W-1:0] idx;
      logic [7:0]       data;
   } hua_wr_type;

   // start of a result run
   typedef struct packed {
      logic             valid;
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             found;
   } hua_start_type;

   // characters of "GET"
   function automatic logic [7:0] prefix_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h47;
         2'd1:    c = 8'h45;
         2'd2:    c = 8'h54;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // characters of "User-Agent:"
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h55;
         4'd1:    c = 8'h73;
         4'd2:    c = 8'h65;
         4'd3:    c = 8'h72;
         4'd4:    c = 8'h2D;
         4'd5:    c = 8'h41;
         4'd6:    c = 8'h67;
         4'd7:    c = 8'h65;
         4'd8:    c = 8'h6E;
         4'd9:    c = 8'h74;
         4'd10:   c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/hua_buf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP User-Agent buffer RAM
// Two banks of line/agent bytes, one write and one registered read port.
// ----------------------------------------------------------------------------
module hua_buf_ram #(
   parameter int CAP = 63
) (
   input  logic                          clock,
   input  hua_pkg::hua_wr_type           wr,
   input  logic                          rd_en,
   input  logic                          rd_bank,
   input  logic [hua_pkg::CNT_W-1:0]     rd_idx,
   output logic [7:0]                    rd_data
);

   localparam int DEPTH  = 2 * CAP;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [7:0]        mem_ff [0:DEPTH-1];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   // bank one sits above bank zero
   assign wr_addr = wr.bank ? (ADDR_W'(wr.idx) + ADDR_W'(CAP)) : ADDR_W'(wr.idx);
   assign rd_addr = rd_bank ? (ADDR_W'(rd_idx) + ADDR_W'(CAP)) : ADDR_W'(rd_idx);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/hua_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP User-Agent line parser
// Input register, prefix check, line split, key search and agent capture.
// ----------------------------------------------------------------------------
module hua_parser #(
   parameter int CAP = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tuser,
   input  logic                    req_tlast,
   input  logic                    drain_busy,
   output hua_pkg::hua_wr_type     wr,
   output hua_pkg::hua_start_type  start
);

   localparam logic [hua_pkg::CNT_W-1:0] CAP_CNT = hua_pkg::CNT_W'(CAP);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_last_ff;
   logic       proc_fire;
   logic       req_fire;
   logic [7:0] line_val;

   logic [1:0]                 prefix_count_ff, prefix_count_in;
   logic                       get_seen_ff, get_seen_in;
   logic                       skip_after_cr_ff, skip_after_cr_in;
   logic [3:0]                 key_progress_ff, key_progress_in;
   logic                       line_has_key_ff, line_has_key_in;
   logic [hua_pkg::CNT_W-1:0]  line_count_ff, line_count_in;
   logic                       line_stopped_ff, line_stopped_in;
   logic [hua_pkg::CNT_W-1:0]  agent_count_ff, agent_count_in;
   logic                       agent_seen_ff, agent_seen_in;
   logic                       agent_bank_ff, agent_bank_in;

   // hold the byte while a result run is still being read out
   assign proc_fire  = in_valid_ff & ~drain_busy;
   assign req_tready = ~in_valid_ff | proc_fire;
   assign req_fire   = req_tvalid & req_tready;
   assign in_valid_in = req_fire | (in_valid_ff & ~proc_fire);
   assign line_val   = (in_byte_ff == hua_pkg::BYTE_COMMA) ? hua_pkg::BYTE_SEMI : in_byte_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   always_comb begin
      prefix_count_in  = prefix_count_ff;
      get_seen_in      = get_seen_ff;
      skip_after_cr_in = skip_after_cr_ff;
      key_progress_in  = key_progress_ff;
      line_has_key_in  = line_has_key_ff;
      line_count_in    = line_count_ff;
      line_stopped_in  = line_stopped_ff;
      agent_count_in   = agent_count_ff;
      agent_seen_in    = agent_seen_ff;
      agent_bank_in    = agent_bank_ff;
      wr               = '0;
      start            = '0;
      if (proc_fire) begin
         if (in_first_ff) begin
            prefix_count_in  = '0;
            get_seen_in      = 1'b0;
            skip_after_cr_in = 1'b0;
            key_progress_in  = '0;
            line_has_key_in  = 1'b0;
            line_count_in    = '0;
            line_stopped_in  = 1'b0;
            agent_count_in   = '0;
            agent_seen_in    = 1'b0;
         end
         if (prefix_count_in != 2'(hua_pkg::PREFIX_LEN)) begin
            if (in_byte_ff == hua_pkg::prefix_char(prefix_count_in)) begin
               get_seen_in     = (prefix_count_in == 2'(hua_pkg::PREFIX_LEN - 1));
               prefix_count_in = prefix_count_in + 2'd1;
            end else begin
               prefix_count_in = 2'(hua_pkg::PREFIX_LEN);
               get_seen_in     = 1'b0;
            end
         end else if (!get_seen_in) begin
            prefix_count_in = prefix_count_in;
         end else if (skip_after_cr_in) begin
            skip_after_cr_in = 1'b0;
         end else if (in_byte_ff == hua_pkg::BYTE_CR) begin
            // swap banks when the finished line holds the key: it becomes the agent
            if (line_has_key_in) begin
               agent_bank_in  = ~agent_bank_ff;
               agent_count_in = line_count_in;
               agent_seen_in  = 1'b1;
            end
            key_progress_in  = '0;
            line_has_key_in  = 1'b0;
            line_count_in    = '0;
            line_stopped_in  = 1'b0;
            skip_after_cr_in = 1'b1;
         end else begin
            if (!line_stopped_in) begin
               if (line_val == hua_pkg::BYTE_NUL) begin
                  line_stopped_in = 1'b1;
               end else if (line_count_in < CAP_CNT) begin
                  wr.en         = 1'b1;
                  wr.bank       = ~agent_bank_ff;
                  wr.idx        = line_count_in;
                  wr.data       = line_val;
                  line_count_in = line_count_in + 1'b1;
               end
            end
            if (line_val == hua_pkg::key_char(key_progress_in)) begin
               key_progress_in = key_progress_in + 4'd1;
            end else begin
               key_progress_in = (line_val == hua_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
            end
            if (key_progress_in == 4'(hua_pkg::KEY_LEN)) begin
               line_has_key_in = 1'b1;
               key_progress_in = '0;
            end
         end
         if (in_last_ff) begin
            start.valid      = 1'b1;
            start.bank       = agent_bank_in;
            start.count      = agent_count_in;
            start.found      = agent_seen_in;
            prefix_count_in  = '0;
            get_seen_in      = 1'b0;
            skip_after_cr_in = 1'b0;
            key_progress_in  = '0;
            line_has_key_in  = 1'b0;
            line_count_in    = '0;
            line_stopped_in  = 1'b0;
            agent_count_in   = '0;
            agent_seen_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         prefix_count_ff  <= '0;
         get_seen_ff      <= 1'b0;
         skip_after_cr_ff <= 1'b0;
         key_progress_ff  <= '0;
         line_has_key_ff  <= 1'b0;
         line_count_ff    <= '0;
         line_stopped_ff  <= 1'b0;
         agent_count_ff   <= '0;
         agent_seen_ff    <= 1'b0;
         agent_bank_ff    <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         prefix_count_ff  <= prefix_count_in;
         get_seen_ff      <= get_seen_in;
         skip_after_cr_ff <= skip_after_cr_in;
         key_progress_ff  <= key_progress_in;
         line_has_key_ff  <= line_has_key_in;
         line_count_ff    <= line_count_in;
         line_stopped_ff  <= line_stopped_in;
         agent_count_ff   <= agent_count_in;
         agent_seen_ff    <= agent_seen_in;
         agent_bank_ff    <= agent_bank_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (line_count_ff <= CAP_CNT) && (agent_count_ff <= CAP_CNT))
      else $error("line or agent count above capacity");

endmodule

>>> hw/rtl/hua_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP User-Agent result drain
// Read sequencer over the agent bank and the output register stage.
// ----------------------------------------------------------------------------
module hua_drain (
   input  logic                          clock,
   input  logic                          reset,
   input  hua_pkg::hua_start_type        start,
   output logic                          drain_busy,
   output logic                          rd_en,
   output logic                          rd_bank,
   output logic [hua_pkg::CNT_W-1:0]     rd_idx,
   input  logic [7:0]                    rd_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   logic                       active_ff, active_in;
   logic                       bank_ff;
   logic [hua_pkg::CNT_W-1:0]  cnt_ff;
   logic [hua_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic                       found_ff;
   logic                       has_bytes;
   logic                       issue;
   logic                       issue_last;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_zero_ff;
   logic                       s1_last_ff;
   logic                       s1_found_ff;
   logic [hua_pkg::CNT_W-1:0]  s1_len_ff;

   logic                       s2_valid_ff, s2_valid_in;
   logic [7:0]                 s2_byte_ff;
   logic [hua_pkg::CNT_W-1:0]  s2_len_ff;
   logic                       s2_found_ff;
   logic                       s2_last_ff;

   logic                       s2_load;
   logic                       s1_free;

   assign has_bytes  = found_ff & (cnt_ff != '0);
   assign s2_load    = s1_valid_ff & (~s2_valid_ff | rsp_tready);
   assign s1_free    = ~s1_valid_ff | s2_load;
   assign issue      = active_ff & s1_free;
   assign issue_last = ~has_bytes | (idx_ff == cnt_ff - 1'b1);

   assign rd_en   = issue & has_bytes;
   assign rd_bank = bank_ff;
   assign rd_idx  = idx_ff;

   assign active_in   = start.valid | (active_ff & ~(issue & issue_last));
   assign idx_in      = start.valid ? '0 : (issue ? idx_ff + 1'b1 : idx_ff);
   assign s1_valid_in = issue | (s1_valid_ff & ~s2_load);
   assign s2_valid_in = s2_load | (s2_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (start.valid) begin
         bank_ff  <= start.bank;
         cnt_ff   <= start.count;
         found_ff <= start.found;
      end
      if (issue) begin
         s1_zero_ff  <= ~has_bytes;
         s1_last_ff  <= issue_last;
         s1_found_ff <= found_ff;
         s1_len_ff   <= has_bytes ? cnt_ff : '0;
      end
      if (s2_load) begin
         s2_byte_ff  <= s1_zero_ff ? 8'd0 : rd_data;
         s2_len_ff   <= s1_len_ff;
         s2_found_ff <= s1_found_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         idx_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         idx_ff      <= idx_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   assign drain_busy = active_ff;
   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {2'b00, s2_len_ff, s2_byte_ff};
   assign rsp_tuser  = s2_found_ff;
   assign rsp_tlast  = s2_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      start.valid |-> !active_ff)
      else $error("new result run started while a run is being read");

   assert property (@(posedge clock) disable iff (reset)
      (active_ff && has_bytes) |-> (idx_ff < cnt_ff))
      else $error("read index ran past the agent length");

   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && (s2_len_ff == '0)) |-> s2_last_ff)
      else $error("empty result not marked as last");

endmodule

>>> hw/rtl/http_user_agent_extract_unit.sv
`timescale 1ns / 1ps
// Path: a closing byte passes the input register, drain sequencer, read stage and output register.
// Throughput: one payload byte per cycle; a closing byte starts a run of one result per
//   cycle while rsp_tready is high (up to AGENT_LEN-1, at most 63), and input bytes are
//   held while that run is read out of the single read port of the buffer RAM.
// Reset: synchronous, clears all parse state and empties the pipeline; buffer RAM
//   contents are left as they are and read only after being written.
// ----------------------------------------------------------------------------
// HTTP User-Agent extract unit
// Captures the User-Agent line of a GET payload and streams it out byte by byte.
// ----------------------------------------------------------------------------
module http_user_agent_extract_unit #(
   parameter int AGENT_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input transaction: one payload byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first_item
   input  logic        req_tlast,   // last_item
   // result transaction: one agent byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] agent_byte, [13:8] agent_length, [15:14] zero
   output logic        rsp_tuser,   // [0] agent_found
   output logic        rsp_tlast    // last_result
);

   // capture limit: agent bytes kept per line, bounded by the 6-bit length field
   localparam int CAP = ((AGENT_LEN - 1) > 63) ? 63 : (AGENT_LEN - 1);

   hua_pkg::hua_wr_type         wr;
   hua_pkg::hua_start_type      start;
   logic                        drain_busy;
   logic                        rd_en;
   logic                        rd_bank;
   logic [hua_pkg::CNT_W-1:0]   rd_idx;
   logic [7:0]                  rd_data;

   // Parser: registers each byte, then in one pass checks the GET prefix, splits
   // lines at CR (dropping the byte after it), maps comma to semicolon, stores the
   // line into the free bank and hunts for the key. A CR that ends a key line flips
   // the bank roles, so the line becomes the agent with no copy.
   hua_parser #(
      .CAP (CAP)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .drain_busy (drain_busy),
      .wr         (wr),
      .start      (start)
   );

   // Buffer RAM: two banks, line bank written by the parser, agent bank read by
   // the drain.
   hua_buf_ram #(
      .CAP (CAP)
   ) u_buf_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_bank (rd_bank),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   // Drain: walk the agent bank one byte a cycle while the output is not stalled, or emit
   // the single empty result, through a read stage and the output register.
   hua_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .drain_busy (drain_busy),
      .rd_en      (rd_en),
      .rd_bank    (rd_bank),
      .rd_idx     (rd_idx),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP User-Agent extract testbench
// Streams GET payloads, some clean and some damaged, into the extractor byte by
// byte. Every accepted byte updates a local parser, which queues the agent
// bytes due at each closing byte. Each result transaction is checked against
// that queue. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int AGENT_LEN = 64;
   localparam int AGENT_CAP = (AGENT_LEN - 1 > 63) ? 63 : AGENT_LEN - 1;
   localparam logic [23:0] GET_TEXT = "GET";
   localparam logic [87:0] UA_KEY   = "User-Agent:";

   // one payload byte waiting for the driver
   typedef struct {
      logic [7:0] data;
      logic       opens;
      logic       closes;
      logic       drain;   // hold this byte back until every agent byte has come in
   } payload_byte_type;

   // one agent byte as the extractor should send it
   typedef struct {
      logic [7:0] agent_byte;
      logic [5:0] agent_length;
      logic       agent_found;
      logic       last_result;
   } agent_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   payload_byte_type payload_q[$];
   agent_beat_type   agent_beats_q[$];
   logic [7:0]       build_q[$];
   payload_byte_type next_byte;
   agent_beat_type   due_beat;
   bit            req_taken = 1'b0;
   int            req_count = 0;
   int            rsp_count = 0;
   int            mismatch_count = 0;
   int            stall_left = 0;
   bit            stall_done = 1'b0;

   // parser state as the extractor should hold it
   logic [1:0] pfx_seen;
   logic       is_get;
   logic       drop_next;
   logic [3:0] key_pos;
   logic       line_keyed;
   logic [5:0] line_len;
   logic       line_nul;
   logic [7:0] line_buf[AGENT_CAP];
   logic [7:0] agent_buf[AGENT_CAP];
   logic [5:0] agent_len;
   logic       agent_valid;

   http_user_agent_extract_unit #(
      .AGENT_LEN(AGENT_LEN)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] ua_key_char(input logic [3:0] idx);
      return UA_KEY[8*(hua_pkg::KEY_LEN-1-idx) +: 8];
   endfunction

   function automatic void clear_line_state();
      key_pos    = '0;
      line_keyed = 1'b0;
      line_len   = '0;
      line_nul   = 1'b0;
   endfunction

   function automatic void clear_capture();
      pfx_seen    = '0;
      is_get      = 1'b0;
      drop_next   = 1'b0;
      agent_len   = '0;
      agent_valid = 1'b0;
      clear_line_state();
   endfunction

   // advance the parser by one accepted byte and queue the agent bytes it releases
   function automatic void predict_agent_beats(input logic [7:0] b, input logic opens,
                                               input logic closes);
      logic [7:0]     v;
      agent_beat_type beat;
      if (opens) clear_capture();
      if (pfx_seen < hua_pkg::PREFIX_LEN) begin
         // match "GET"; any miss spoils the whole payload
         if (b == GET_TEXT[8*(hua_pkg::PREFIX_LEN-1-pfx_seen) +: 8]) begin
            pfx_seen = pfx_seen + 2'd1;
            if (pfx_seen == hua_pkg::PREFIX_LEN) is_get = 1'b1;
         end else begin
            pfx_seen = 2'(hua_pkg::PREFIX_LEN);
            is_get   = 1'b0;
         end
      end else if (is_get) begin
         if (drop_next) begin
            drop_next = 1'b0;
         end else if (b == hua_pkg::BYTE_CR) begin
            // a keyed line replaces the captured agent when its CR arrives
            if (line_keyed) begin
               for (int i = 0; i < line_len; i++) agent_buf[i] = line_buf[i];
               agent_len   = line_len;
               agent_valid = 1'b1;
            end
            clear_line_state();
            drop_next = 1'b1;
         end else begin
            v = (b == hua_pkg::BYTE_COMMA) ? hua_pkg::BYTE_SEMI : b;
            if (!line_nul) begin
               if (v == hua_pkg::BYTE_NUL) begin
                  line_nul = 1'b1;
               end else if (line_len < AGENT_CAP) begin
                  line_buf[line_len] = v;
                  line_len = line_len + 6'd1;
               end
            end
            // key search runs on past a NUL
            if (key_pos < hua_pkg::KEY_LEN && v == ua_key_char(key_pos))
               key_pos = key_pos + 4'd1;
            else key_pos = (v == ua_key_char(4'd0)) ? 4'd1 : 4'd0;
            if (key_pos >= hua_pkg::KEY_LEN) begin
               line_keyed = 1'b1;
               key_pos    = '0;
            end
         end
      end
      if (closes) begin
         if (agent_valid && agent_len != 0) begin
            for (int k = 0; k < agent_len; k++) begin
               beat.agent_byte   = agent_buf[k];
               beat.agent_length = agent_len;
               beat.agent_found  = 1'b1;
               beat.last_result  = (k == agent_len - 1);
               agent_beats_q.push_back(beat);
            end
         end else begin
            beat.agent_byte   = '0;
            beat.agent_length = '0;
            beat.agent_found  = agent_valid;
            beat.last_result  = 1'b1;
            agent_beats_q.push_back(beat);
         end
         clear_capture();
      end
   endfunction

   // idle with a chance of 38 in 100, except through a quiet stretch of the run
   function automatic bit take_break();
      if (req_count >= 80 && req_count < 200) return 1'b0;
      return $urandom_range(99) < 38;
   endfunction

   task automatic add_text(input string t);
      for (int i = 0; i < t.len(); i++) build_q.push_back(t[i]);
   endtask

   // line content: mostly printable, with commas, NULs and raw bytes mixed in
   task automatic add_content(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 8) build_q.push_back(hua_pkg::BYTE_COMMA);
         else if (r < 11) build_q.push_back(hua_pkg::BYTE_NUL);
         else if (r < 20) build_q.push_back(8'($urandom_range(255)));
         else build_q.push_back(8'($urandom_range(126, 32)));
      end
   endtask

   // move the built payload to the driver queue; now and then reopen it midway
   task automatic commit_payload(input bit with_open, input bit drain_first);
      int               cut;
      payload_byte_type item;
      if (build_q.size() == 0) build_q.push_back(8'($urandom_range(255)));
      cut = ($urandom_range(19) == 0) ? $urandom_range(build_q.size() - 1) : -1;
      for (int i = 0; i < build_q.size(); i++) begin
         item.data   = build_q[i];
         item.opens  = (i == 0) ? with_open : (i == cut);
         item.closes = (i == build_q.size() - 1);
         item.drain  = (i == 0) && drain_first;
         payload_q.push_back(item);
      end
      build_q.delete();
   endtask

   // driver: change inputs on the falling edge, hold a byte until it is taken
   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_taken)) begin
         req_taken = 1'b0;
         if (payload_q.size() != 0 && !take_break() &&
             !(payload_q[0].drain && agent_beats_q.size() != 0)) begin
            next_byte = payload_q.pop_front();
            req_tdata  <= next_byte.data;
            req_tuser  <= next_byte.opens;
            req_tlast  <= next_byte.closes;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off so the extractor backs up
   always @(negedge clock) begin
      if (!reset) begin
         if (!stall_done && rsp_count >= 30) begin
            stall_done = 1'b1;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !take_break();
         end
      end
   end

   // monitor: sample both sides on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            req_count = req_count + 1;
            predict_agent_beats(req_tdata, req_tuser, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count = rsp_count + 1;
            if (agent_beats_q.size() == 0) begin
               $display("%0t: unexpected result: byte=%h len=%0d found=%b last=%b pad=%b",
                        $time, rsp_tdata[7:0], rsp_tdata[13:8], rsp_tuser, rsp_tlast,
                        rsp_tdata[15:14]);
               mismatch_count = mismatch_count + 1;
            end else begin
               due_beat = agent_beats_q.pop_front();
               if (rsp_tdata[7:0] !== due_beat.agent_byte ||
                   rsp_tdata[13:8] !== due_beat.agent_length ||
                   rsp_tdata[15:14] !== 2'b00 ||
                   rsp_tuser !== due_beat.agent_found ||
                   rsp_tlast !== due_beat.last_result) begin
                  $display("%0t: expected byte=%h len=%0d found=%b last=%b,",
                           $time, due_beat.agent_byte, due_beat.agent_length,
                           due_beat.agent_found, due_beat.last_result,
                           " actual byte=%h len=%0d found=%b last=%b pad=%b",
                           rsp_tdata[7:0], rsp_tdata[13:8], rsp_tuser, rsp_tlast,
                           rsp_tdata[15:14]);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
   end

   initial begin
      int added;
      int kind;
      int nlines;
      clear_capture();

      // keyed line with a NUL up front: found, but nothing kept
      build_q.push_back(8'h47);
      build_q.push_back(8'h45);
      build_q.push_back(8'h54);
      build_q.push_back(hua_pkg::BYTE_NUL);
      add_text("User-Agent:");
      build_q.push_back(hua_pkg::BYTE_CR);
      build_q.push_back(8'hFF);
      build_q.push_back(hua_pkg::BYTE_COMMA);
      commit_payload(1'b1, 1'b0);
      // one-byte payload that is not GET; wait for the agent bytes first
      build_q.push_back(8'hFF);
      commit_payload(1'b1, 1'b1);
      // short prefix, opened only by the previous closing byte
      add_text("GE");
      commit_payload(1'b0, 1'b0);

      added = 0;
      while (added < 320) begin
         kind = $urandom_range(99);
         if (kind < 12) begin
            add_content($urandom_range(2, 1));
         end else begin
            add_text("GET");
            if (kind < 20) build_q[$urandom_range(2)] = 8'($urandom_range(255));
            nlines = $urandom_range(3);
            for (int l = 0; l < nlines; l++) begin
               if ($urandom_range(1) == 1) begin
                  add_content($urandom_range(2));
                  add_text("User-Agent:");
                  // damage the key now and then
                  if ($urandom_range(9) == 0)
                     build_q[build_q.size() - 1 - $urandom_range(10)] =
                        8'($urandom_range(255));
                  add_content(($urandom_range(9) == 0) ? $urandom_range(72, 50)
                                                        : $urandom_range(10));
               end else begin
                  add_content($urandom_range(4));
               end
               // leave the final line open about one time in five
               if (l < nlines - 1 || $urandom_range(4) != 0) begin
                  build_q.push_back(hua_pkg::BYTE_CR);
                  build_q.push_back(8'($urandom_range(255)));
               end
            end
         end
         added = added + ((build_q.size() == 0) ? 1 : build_q.size());
         commit_payload($urandom_range(9) != 0, $urandom_range(19) == 0);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (payload_q.size() != 0 || req_tvalid) @(posedge clock);
      while (agent_beats_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> http_user_agent_extract_unit.f
hw/rtl/hua_pkg.sv
hw/rtl/hua_buf_ram.sv
hw/rtl/hua_parser.sv
hw/rtl/hua_drain.sv
hw/rtl/http_user_agent_extract_unit.sv
sim/tb.sv
